/* rtl/tphe_pkg.sv */
// shared types and constants for the touch pad press/hold event block
// no dependencies; imported by the interfaces and every module
package tphe_pkg;

    localparam int CNT_W  = 10;
    localparam int PAD_W  = 4;
    localparam int IDX_W  = 2;
    localparam int KIND_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX    = 10'd1023;
    localparam logic [CNT_W-1:0] HOLD_RESET = 10'd25;

    typedef enum logic [KIND_W-1:0] {
        EV_DOWN = 2'd0,
        EV_UP   = 2'd1,
        EV_HOLD = 2'd2
    } ev_kind_t;

    typedef struct packed {
        logic     hit;
        ev_kind_t kind;
    } lane_ev_t;

    typedef struct packed {
        logic busy;
        logic single;
    } merge_stat_t;

endpackage

/* rtl/tphe_ifs.sv */
// valid/ready channel interfaces: poll ticks, events and the config write
// depends on tphe_pkg
interface tphe_tick_if
    import tphe_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PAD_W-1:0] pad_pressed;

    modport source (output valid, output pad_pressed, input ready);
    modport sink (input valid, input pad_pressed, output ready);
endinterface

interface tphe_event_if
    import tphe_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  pad_index;
    logic [KIND_W-1:0] event_kind;
    logic              last_event;

    modport source (output valid, output pad_index, output event_kind, output last_event,
                    input ready);
    modport sink (input valid, input pad_index, input event_kind, input last_event,
                  output ready);
endinterface

interface tphe_cfg_if
    import tphe_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/tphe_lane.sv */
// one pad lane: edge history, hold flag and saturating tick counter
// depends on tphe_pkg
module tphe_lane
    import tphe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic             now,
    input  logic [CNT_W-1:0] hold_ticks,
    output lane_ev_t         ev
);

    logic             was_reg, was_next;
    logic             hrep_reg, hrep_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_inc;

    always_comb
    begin
        cnt_inc   = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        ev.hit    = 1'b0;
        ev.kind   = EV_DOWN;
        hrep_next = 1'b0;
        cnt_next  = '0;
        was_next  = now;
        if (now && !was_reg)
        begin
            ev.hit  = 1'b1;
            ev.kind = EV_DOWN;
        end
        else if (!now && was_reg)
        begin
            ev.hit  = 1'b1;
            ev.kind = EV_UP;
        end
        else if (now)
        begin
            cnt_next  = cnt_inc;
            hrep_next = hrep_reg;
            if (!hrep_reg && (cnt_inc >= hold_ticks))
            begin
                ev.hit    = 1'b1;
                ev.kind   = EV_HOLD;
                hrep_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_reg  <= 1'b0;
            hrep_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (fire)
        begin
            was_reg  <= was_next;
            hrep_reg <= hrep_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* rtl/tphe_merge.sv */
// merging stage: latches the lane events of one item and sends them out lowest pad
// first, one per cycle unless stalled, via an output register; depends on tphe_pkg
module tphe_merge
    import tphe_pkg::*;
#(
    parameter int NUM_PADS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  lane_ev_t            ev [NUM_PADS],
    input  logic                in_fire,
    output logic                in_ready,
    output merge_stat_t         stat,
    tphe_event_if.source        events
);

    logic [NUM_PADS-1:0] pend_reg, pend_next;
    ev_kind_t            kind_reg [NUM_PADS];
    logic [NUM_PADS-1:0] low;
    logic [NUM_PADS-1:0] pend_after;
    logic [NUM_PADS-1:0] hits;
    logic                move;
    logic [IDX_W-1:0]    sel_idx;
    logic [KIND_W-1:0]   sel_kind;

    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic                out_last_reg;

    always_comb
    begin
        low        = pend_reg & (~pend_reg + 1'b1);
        pend_after = pend_reg & ~low;
        move       = (|pend_reg) && (!out_valid_reg || events.ready);
        in_ready   = (pend_reg == '0) || (move && (pend_after == '0));
        sel_idx    = '0;
        sel_kind   = '0;
        for (int i = 0; i < NUM_PADS; i++)
        begin
            hits[i] = ev[i].hit;
            if (low[i])
            begin
                sel_idx  = sel_idx | IDX_W'(i);
                sel_kind = sel_kind | kind_reg[i];
            end
        end
        if (in_fire)
            pend_next = hits;
        else if (move)
            pend_next = pend_after;
        else
            pend_next = pend_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (events.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
        stat.busy   = |pend_reg;
        stat.single = (pend_after == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < NUM_PADS; i++)
                kind_reg[i] <= ev[i].kind;
        end
        if (move)
        begin
            out_idx_reg  <= sel_idx;
            out_kind_reg <= sel_kind;
            out_last_reg <= (pend_after == '0);
        end
    end

    assign events.valid      = out_valid_reg;
    assign events.pad_index  = out_idx_reg;
    assign events.event_kind = out_kind_reg;
    assign events.last_event = out_last_reg;

endmodule

/* rtl/touch_pad_press_hold_events_top.sv */
// touch pad press/hold events: one lane per pad, events merged in pad order
// the first event of a tick goes through the pending mask, then the output register;
// a new tick can be accepted as the last event of the one before moves; events leave
// one per cycle unless stalled, via the single output register of the merging stage
// reset clears pad history, counters and pending events; hold_ticks returns to 25
module touch_pad_press_hold_events_top
    import tphe_pkg::*;
#(
    parameter int NUM_PADS = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    tphe_tick_if.sink     tick,
    tphe_cfg_if.sink      cfg,
    tphe_event_if.source  events
);

    logic [CNT_W-1:0]    hold_ticks_reg;
    logic [NUM_PADS-1:0] now;
    lane_ev_t            ev [NUM_PADS];
    logic                in_fire;
    logic                in_ready;
    merge_stat_t         stat;

    assign cfg.ready  = 1'b1;
    assign tick.ready = in_ready;
    assign in_fire    = tick.valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_ticks_reg <= HOLD_RESET;
        else if (cfg.valid)
            hold_ticks_reg <= cfg.data;
    end

    for (genvar i = 0; i < NUM_PADS; i++)
    begin : g_lane
        if (i < PAD_W)
        begin : g_in
            assign now[i] = tick.pad_pressed[i];
        end
        else
        begin : g_none
            assign now[i] = 1'b0;
        end

        tphe_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .fire       (in_fire),
            .now        (now[i]),
            .hold_ticks (hold_ticks_reg),
            .ev         (ev[i])
        );
    end

    tphe_merge #(
        .NUM_PADS (NUM_PADS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ev       (ev),
        .in_fire  (in_fire),
        .in_ready (in_ready),
        .stat     (stat),
        .events   (events)
    );

`ifndef SYNTHESIS
    // a new item only enters when at most the event now moving is left
    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!stat.busy || stat.single))
        else $error("tick accepted over pending events");

    // an event that is not the last of its tick is followed at once by the next
    a_next_event: assert property (@(posedge clk) disable iff (!rst_n)
        (events.valid && events.ready && !events.last_event) |=> events.valid)
        else $error("gap inside the events of one tick");

    // a shown event that is not the last has its successors still pending
    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (events.valid && !events.last_event) |-> stat.busy)
        else $error("non-final event with nothing pending");
`endif

endmodule
